>>> rtl/kcc_pkg.sv
package kcc_pkg;

  localparam int CATEGORIES            = 3;
  localparam int KEYWORDS_PER_CATEGORY = 5;
  localparam int KEYWORD_BYTES         = 8;
  localparam int LINE_BYTES            = 255;

  localparam int SLOT_COUNT   = CATEGORIES * KEYWORDS_PER_CATEGORY;
  localparam int LEN_W        = $clog2(KEYWORD_BYTES + 1);
  localparam int LINE_COUNT_W = $clog2(LINE_BYTES + 1);
  localparam int SCORE_W      = 16;
  localparam int HIT_COUNT_W  = $clog2(KEYWORDS_PER_CATEGORY + 1);

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_EOL     = 3'd1,
    KIND_EOT     = 3'd2,
    KIND_KW_BYTE = 3'd3,
    KIND_KW_LEN  = 3'd4
  } kind_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [KEYWORD_BYTES-1:0] window_t;
  typedef logic [LEN_W-1:0] kw_len_t;
  typedef logic [LINE_COUNT_W-1:0] line_count_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef score_t [CATEGORIES-1:0] score_row_t;

  // window cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // keyword table write, broadcast to all slot cells
  typedef struct packed {
    logic    byte_en;
    logic    len_en;
    logic [2:0] pos;
    byte_t   value;
    kw_len_t len;
  } kw_wr_t;

  // per-byte match control, broadcast to all slot cells
  typedef struct packed {
    logic        take;
    logic        clear;
    line_count_t count;
  } slot_ctl_t;

  typedef struct packed {
    logic close;
    logic finish;
  } score_ctl_t;

endpackage

>>> rtl/kcc_if.sv
interface kcc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic [3:0] keyword_slot;
  logic [2:0] keyword_pos;
  logic [3:0] keyword_len;

  modport source (output valid, kind, byte_value, keyword_slot, keyword_pos, keyword_len,
                  input ready);
  modport sink (input valid, kind, byte_value, keyword_slot, keyword_pos, keyword_len,
                output ready);
endinterface

interface kcc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] score_first;
  logic [15:0] score_second;
  logic [15:0] score_third;
  logic [1:0]  best_category;
  logic        classified;
  logic        no_text;

  modport source (output valid, score_first, score_second, score_third, best_category,
                  classified, no_text, input ready);
  modport sink (input valid, score_first, score_second, score_third, best_category,
                classified, no_text, output ready);
endinterface

>>> rtl/kcc_win_cell.sv
module kcc_win_cell (
  input  logic              clk,
  input  logic              rst,
  input  kcc_pkg::win_ctl_t ctl,
  input  kcc_pkg::byte_t    prev,
  output kcc_pkg::byte_t    data
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      data <= '0;
    end else if (ctl.shift) begin
      data <= prev;
    end
  end

endmodule

>>> rtl/kcc_slot_cell.sv
module kcc_slot_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               sel,
  input  kcc_pkg::kw_wr_t    wr,
  input  kcc_pkg::slot_ctl_t ctl,
  input  kcc_pkg::window_t   window,
  output logic               hit
);

  localparam int LEN_DEPTH = 2 ** kcc_pkg::LEN_W;

  kcc_pkg::byte_t  kw [kcc_pkg::KEYWORD_BYTES];
  kcc_pkg::kw_len_t len;
  logic            hit_q;
  logic [LEN_DEPTH-1:0] match_len;
  logic            ok;
  logic            hit_now;

  // keyword bytes hold no reset; length resets to unused
  always_ff @(posedge clk) begin
    for (int p = 0; p < kcc_pkg::KEYWORD_BYTES; p++) begin
      if (sel && wr.byte_en && 32'(wr.pos) == p) begin
        kw[p] <= wr.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (sel && wr.len_en) begin
      len <= wr.len;
    end
  end

  // match for every candidate length, newest byte at window[0]
  always_comb begin
    match_len = '0;
    for (int l = 1; l <= kcc_pkg::KEYWORD_BYTES; l++) begin
      ok = 1'b1;
      for (int p = 0; p < l; p++) begin
        ok = ok & (kw[p] == window[l-1-p]);
      end
      match_len[l] = ok;
    end
  end

  assign hit_now = ctl.take && (len != '0) && (32'(ctl.count) >= 32'(len)) && match_len[len];
  assign hit     = hit_q | hit_now;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hit_q <= 1'b0;
    end else if (hit_now) begin
      hit_q <= 1'b1;
    end
  end

endmodule

>>> rtl/kcc_score.sv
module kcc_score (
  input  logic                                clk,
  input  logic                                rst,
  input  kcc_pkg::score_ctl_t                 ctl,
  input  logic [kcc_pkg::SLOT_COUNT-1:0]      hits,
  output kcc_pkg::score_row_t                 scores_sum,
  output logic                                seen_sum
);

  kcc_pkg::score_row_t scores;
  logic seen;
  logic [kcc_pkg::HIT_COUNT_W-1:0] cnt [kcc_pkg::CATEGORIES];
  logic [kcc_pkg::SCORE_W:0]       wide [kcc_pkg::CATEGORIES];

  always_comb begin
    for (int c = 0; c < kcc_pkg::CATEGORIES; c++) begin
      cnt[c] = '0;
      for (int k = 0; k < kcc_pkg::KEYWORDS_PER_CATEGORY; k++) begin
        cnt[c] = cnt[c] + kcc_pkg::HIT_COUNT_W'(hits[c*kcc_pkg::KEYWORDS_PER_CATEGORY + k]);
      end
      wide[c] = {1'b0, scores[c]} + (kcc_pkg::SCORE_W + 1)'(cnt[c]);
      if (!ctl.close) begin
        scores_sum[c] = scores[c];
      end else if (wide[c][kcc_pkg::SCORE_W]) begin
        scores_sum[c] = '1;
      end else begin
        scores_sum[c] = wide[c][kcc_pkg::SCORE_W-1:0];
      end
    end
  end

  assign seen_sum = seen | ctl.close;

  always_ff @(posedge clk) begin
    if (rst || ctl.finish) begin
      scores <= '0;
      seen   <= 1'b0;
    end else begin
      scores <= scores_sum;
      seen   <= seen_sum;
    end
  end

endmodule

>>> rtl/keyword_category_classifier.sv
// Channel  Dir  Payload
// items    in   kind, byte_value, keyword_slot, keyword_pos, keyword_len
// results  out  score_first/second/third, best_category, classified, no_text
//
// One item per cycle; every slot cell compares against the byte window chain
// in the cycle the byte is taken, and line scoring happens in that same cycle.
// An end-of-text marker loads its result into the output register, valid in the next cycle.
// Synchronous reset clears line state, scores and keyword lengths; no clearing pass.
// Items stall only while a result sits in the output register and is not taken.
module keyword_category_classifier (
  input  logic                clk,
  input  logic                rst,
  kcc_item_if.sink            items,
  kcc_result_if.source        results
);

  logic                   take_item;
  logic                   is_text;
  logic                   is_eol;
  logic                   is_eot;
  logic                   is_kw_byte;
  logic                   is_kw_len;
  logic                   slot_ok;
  logic                   close;
  logic                   line_clear;
  kcc_pkg::line_count_t   count;
  kcc_pkg::line_count_t   count_inc;
  kcc_pkg::window_t       window;
  kcc_pkg::win_ctl_t      win_ctl;
  kcc_pkg::kw_wr_t        kw_wr;
  kcc_pkg::slot_ctl_t     slot_ctl;
  kcc_pkg::score_ctl_t    score_ctl;
  logic [kcc_pkg::SLOT_COUNT-1:0] hits;
  kcc_pkg::score_row_t    scores_sum;
  logic                   seen_sum;

  logic                   res_valid;
  kcc_pkg::score_row_t    res_scores;
  logic                   res_no_text;
  logic [1:0]             best;
  kcc_pkg::score_t        top;

  assign items.ready = !res_valid || results.ready;
  assign take_item   = items.valid && items.ready;

  always_comb begin
    is_text    = 1'b0;
    is_eol     = 1'b0;
    is_eot     = 1'b0;
    is_kw_byte = 1'b0;
    is_kw_len  = 1'b0;
    unique case (kcc_pkg::kind_t'(items.kind))
      kcc_pkg::KIND_TEXT:    is_text    = take_item;
      kcc_pkg::KIND_EOL:     is_eol     = take_item;
      kcc_pkg::KIND_EOT:     is_eot     = take_item;
      kcc_pkg::KIND_KW_BYTE: is_kw_byte = take_item;
      kcc_pkg::KIND_KW_LEN:  is_kw_len  = take_item;
      default: ;
    endcase
  end

  assign count_inc = count + kcc_pkg::LINE_COUNT_W'(1);

  // close on end of line, on a full line, or on end of text with a pending line
  assign close = is_eol
              || (is_text && 32'(count_inc) >= kcc_pkg::LINE_BYTES)
              || (is_eot && count != '0);
  assign line_clear = close || is_eot;

  always_ff @(posedge clk) begin
    if (rst || line_clear) begin
      count <= '0;
    end else if (is_text) begin
      count <= count_inc;
    end
  end

  assign win_ctl.shift = is_text;
  assign win_ctl.clear = line_clear;

  for (genvar i = 0; i < kcc_pkg::KEYWORD_BYTES; i++) begin : g_win
    if (i == 0) begin : g_head
      kcc_win_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (win_ctl),
        .prev (items.byte_value),
        .data (window[i])
      );
    end else begin : g_link
      kcc_win_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (win_ctl),
        .prev (window[i-1]),
        .data (window[i])
      );
    end
  end

  // the comparing window includes the incoming byte
  kcc_pkg::window_t window_new;
  always_comb begin
    window_new[0] = items.byte_value;
    for (int i = 1; i < kcc_pkg::KEYWORD_BYTES; i++) begin
      window_new[i] = window[i-1];
    end
  end

  assign slot_ok       = 32'(items.keyword_slot) < kcc_pkg::SLOT_COUNT;
  assign kw_wr.byte_en = is_kw_byte && slot_ok && 32'(items.keyword_pos) < kcc_pkg::KEYWORD_BYTES;
  assign kw_wr.len_en  = is_kw_len && slot_ok;
  assign kw_wr.pos     = items.keyword_pos;
  assign kw_wr.value   = items.byte_value;
  assign kw_wr.len     = (32'(items.keyword_len) > kcc_pkg::KEYWORD_BYTES)
                       ? kcc_pkg::LEN_W'(kcc_pkg::KEYWORD_BYTES)
                       : kcc_pkg::LEN_W'(items.keyword_len);

  assign slot_ctl.take  = is_text;
  assign slot_ctl.clear = line_clear;
  assign slot_ctl.count = count_inc;

  for (genvar s = 0; s < kcc_pkg::SLOT_COUNT; s++) begin : g_slot
    kcc_slot_cell u_slot (
      .clk    (clk),
      .rst    (rst),
      .sel    (32'(items.keyword_slot) == s),
      .wr     (kw_wr),
      .ctl    (slot_ctl),
      .window (window_new),
      .hit    (hits[s])
    );
  end

  assign score_ctl.close  = close;
  assign score_ctl.finish = is_eot;

  kcc_score u_score (
    .clk        (clk),
    .rst        (rst),
    .ctl        (score_ctl),
    .hits       (hits),
    .scores_sum (scores_sum),
    .seen_sum   (seen_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (is_eot) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // scores stay zero until a line closes, so no_text results carry zeros
  always_ff @(posedge clk) begin
    if (is_eot) begin
      res_scores  <= scores_sum;
      res_no_text <= !seen_sum;
    end
  end

  always_comb begin
    best = '0;
    top  = res_scores[0];
    for (int c = 1; c < kcc_pkg::CATEGORIES; c++) begin
      if (res_scores[c] > top) begin
        top  = res_scores[c];
        best = 2'(c);
      end
    end
  end

  assign results.valid         = res_valid;
  assign results.score_first   = res_scores[0];
  assign results.score_second  = res_scores[1];
  assign results.score_third   = res_scores[2];
  assign results.best_category = best;
  assign results.classified    = top != '0;
  assign results.no_text       = res_no_text;

endmodule
